// ===== rtl/selr_pkg.sv =====
`timescale 1ns / 1ps

package selr_pkg;

    localparam int unsigned IDX_W   = 8;
    localparam int unsigned STEP_W  = 32;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned CFG_A_W = 1;
    localparam int unsigned CFG_D_W = 8;

    localparam logic [IDX_W-1:0] STALE_LIMIT_RST = 8'd3;
    localparam logic [IDX_W-1:0] COUNTER_MAX     = 8'd255;

    typedef enum logic [REQ_W-1:0] {
        REQ_MOVE      = 2'd0,
        REQ_COMMIT    = 2'd1,
        REQ_TELEMETRY = 2'd2,
        REQ_NONE      = 2'd3
    } req_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_PROFILE_COUNT = 1'd0,
        CFG_STALE_LIMIT   = 1'd1
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/selr_mod.sv =====
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module selr_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [selr_pkg::STEP_W-1:0]   dividend,
    input  logic [selr_pkg::IDX_W-1:0]    divisor,
    output logic                          done,
    output logic [selr_pkg::IDX_W-1:0]    remainder
);

    localparam int unsigned CNT_W = $clog2(selr_pkg::STEP_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(selr_pkg::STEP_W - 1);

    logic [selr_pkg::STEP_W-1:0] dvd_reg;
    logic [selr_pkg::IDX_W-1:0]  dvs_reg;
    logic [selr_pkg::IDX_W-1:0]  rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [selr_pkg::IDX_W:0]    rem_shift;
    logic [selr_pkg::IDX_W:0]    rem_sub;
    logic [selr_pkg::IDX_W-1:0]  rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[selr_pkg::STEP_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        // remainder stays below the divisor, so it fits back in IDX_W bits
        if (rem_shift >= {1'b0, dvs_reg})
        begin
            rem_next = rem_sub[selr_pkg::IDX_W-1:0];
        end
        else
        begin
            rem_next = rem_shift[selr_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[selr_pkg::STEP_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/selection_reconciler_top.sv =====
`timescale 1ns / 1ps

// Move item with nonzero profile count: passes PREP, DIV and DONE states; DIV waits on
//   the 32-step remainder unit (one dividend bit per cycle).
// Other items go straight to DONE. The next item is taken once the result is in the
//   output register; in_stall stays high until then, also while the output is stalled.
// Reset (rst_n low, async): shown/wanted/pending/stale counter cleared, profile_count 0,
//   stale_limit 3, output register empty.
module selection_reconciler_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [selr_pkg::CFG_A_W-1:0]    cfg_index,
    input  logic [selr_pkg::CFG_D_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [selr_pkg::REQ_W-1:0]      req_type,
    input  logic signed [selr_pkg::STEP_W-1:0] step_count,
    input  logic [selr_pkg::IDX_W-1:0]      index_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [selr_pkg::IDX_W-1:0]      next_index,
    output logic                            no_choice,
    output logic [selr_pkg::IDX_W-1:0]      shown_index,
    output logic                            command_pending
);

    localparam int unsigned SUM_W = selr_pkg::STEP_W + 2;

    selr_pkg::state_t state_reg, state_next;

    logic [selr_pkg::IDX_W-1:0]  profile_count_reg;
    logic [selr_pkg::IDX_W-1:0]  stale_limit_reg;

    logic [selr_pkg::IDX_W-1:0]  shown_reg, shown_next;
    logic [selr_pkg::IDX_W-1:0]  wanted_reg, wanted_next;
    logic                        pending_reg, pending_next;
    logic [selr_pkg::IDX_W-1:0]  stale_cnt_reg, stale_cnt_next;

    selr_pkg::req_t              req_reg;
    logic [selr_pkg::STEP_W-1:0] step_reg;
    logic [selr_pkg::IDX_W-1:0]  idx_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [selr_pkg::IDX_W-1:0]  next_index_reg;
    logic                        no_choice_reg;
    logic [selr_pkg::IDX_W-1:0]  shown_out_reg;
    logic                        pending_out_reg;

    logic                        in_xfer;
    logic                        div_start;
    logic                        load_out;
    logic                        div_done;
    logic [selr_pkg::IDX_W-1:0]  div_rem;

    logic [SUM_W-1:0]            sum_s;
    logic [SUM_W-1:0]            sum_neg;
    logic                        sum_is_neg;
    logic [selr_pkg::STEP_W-1:0] sum_mag;
    logic [selr_pkg::IDX_W-1:0]  wrap_index;
    logic [selr_pkg::IDX_W-1:0]  cnt_inc;
    logic                        is_move;
    logic                        move_none;

    assign in_xfer   = in_valid && !in_stall;
    assign is_move   = (req_reg == selr_pkg::REQ_MOVE);
    assign move_none = (profile_count_reg == '0);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_count_reg <= '0;
            stale_limit_reg   <= selr_pkg::STALE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (selr_pkg::cfg_addr_t'(cfg_index))
                selr_pkg::CFG_PROFILE_COUNT: profile_count_reg <= cfg_data;
                selr_pkg::CFG_STALE_LIMIT:   stale_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // signed sum of shown index and steps, split into sign and magnitude
    always_comb
    begin
        sum_s      = {{2{step_reg[selr_pkg::STEP_W-1]}}, step_reg}
                   + {{(SUM_W - selr_pkg::IDX_W){1'b0}}, shown_reg};
        sum_neg    = '0 - sum_s;
        sum_is_neg = sum_s[SUM_W-1];
        sum_mag    = sum_is_neg ? sum_neg[selr_pkg::STEP_W-1:0]
                                : sum_s[selr_pkg::STEP_W-1:0];
    end

    selr_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (sum_mag),
        .divisor   (profile_count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // truncated remainder of a negative sum folds to the non-negative residue
    always_comb
    begin
        if (sum_is_neg && (div_rem != '0))
        begin
            wrap_index = profile_count_reg - div_rem;
        end
        else
        begin
            wrap_index = div_rem;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            selr_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if ((selr_pkg::req_t'(req_type) == selr_pkg::REQ_MOVE)
                        && (profile_count_reg != '0))
                    begin
                        state_next = selr_pkg::ST_PREP;
                    end
                    else
                    begin
                        state_next = selr_pkg::ST_DONE;
                    end
                end
            end
            selr_pkg::ST_PREP: state_next = selr_pkg::ST_DIV;
            selr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = selr_pkg::ST_DONE;
                end
            end
            selr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = selr_pkg::ST_IDLE;
                end
            end
            default: state_next = selr_pkg::ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            selr_pkg::ST_IDLE: in_stall  = 1'b0;
            selr_pkg::ST_PREP: div_start = 1'b1;
            selr_pkg::ST_DIV:  ;
            selr_pkg::ST_DONE: load_out  = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    // selection state update, applied when the result is loaded
    always_comb
    begin
        shown_next     = shown_reg;
        wanted_next    = wanted_reg;
        pending_next   = pending_reg;
        stale_cnt_next = stale_cnt_reg;
        cnt_inc        = (stale_cnt_reg == selr_pkg::COUNTER_MAX) ? stale_cnt_reg
                                                                  : stale_cnt_reg + 1'b1;
        case (req_reg)
            selr_pkg::REQ_COMMIT:
            begin
                shown_next     = idx_reg;
                wanted_next    = idx_reg;
                pending_next   = 1'b1;
                stale_cnt_next = '0;
            end
            selr_pkg::REQ_TELEMETRY:
            begin
                if (!pending_reg)
                begin
                    shown_next = idx_reg;
                end
                else if ((idx_reg == wanted_reg) || (cnt_inc >= stale_limit_reg))
                begin
                    shown_next     = idx_reg;
                    wanted_next    = idx_reg;
                    pending_next   = 1'b0;
                    stale_cnt_next = '0;
                end
                else
                begin
                    stale_cnt_next = cnt_inc;
                end
            end
            default: ;
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= selr_pkg::ST_IDLE;
            shown_reg     <= '0;
            wanted_reg    <= '0;
            pending_reg   <= 1'b0;
            stale_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                shown_reg     <= shown_next;
                wanted_reg    <= wanted_next;
                pending_reg   <= pending_next;
                stale_cnt_reg <= stale_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= selr_pkg::req_t'(req_type);
            step_reg <= step_count;
            idx_reg  <= index_value;
        end
        if (load_out)
        begin
            next_index_reg  <= (is_move && !move_none) ? wrap_index : '0;
            no_choice_reg   <= is_move && move_none;
            shown_out_reg   <= shown_next;
            pending_out_reg <= pending_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign next_index      = next_index_reg;
    assign no_choice       = no_choice_reg;
    assign shown_index     = shown_out_reg;
    assign command_pending = pending_out_reg;

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && no_choice_reg |-> next_index_reg == '0)
        else $error("no_choice result carries a nonzero index");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == selr_pkg::ST_DIV)
        else $error("remainder unit finished outside the divide state");

    a_stale_pending: assert property (@(posedge clk) disable iff (!rst_n)
        stale_cnt_reg != '0 |-> pending_reg)
        else $error("stale counter running with no command pending");

    a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg != selr_pkg::ST_IDLE)
        else $error("block idle right after an input transfer");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == selr_pkg::ST_IDLE)
        else $error("result load did not fill output register");

endmodule

// ===== dv/reconcile_monitor.sv =====
`timescale 1ns / 1ps

module reconcile_monitor
    import selr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_A_W-1:0]         cfg_index,
    input  logic [CFG_D_W-1:0]         cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [REQ_W-1:0]           req_type,
    input  logic signed [STEP_W-1:0]   step_count,
    input  logic [IDX_W-1:0]           index_value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [IDX_W-1:0]           next_index,
    input  logic                       no_choice,
    input  logic [IDX_W-1:0]           shown_index,
    input  logic                       command_pending,
    output int                         mismatches,
    output int                         in_flight,
    output int                         results_checked
);

    typedef struct packed {
        logic [IDX_W-1:0] next_index;
        logic             no_choice;
        logic [IDX_W-1:0] shown_index;
        logic             command_pending;
    } panel_view_t;

    // shadow of the block's registers and state
    logic [IDX_W-1:0] profiles;
    logic [IDX_W-1:0] stale_max;
    logic [IDX_W-1:0] shown_q;
    logic [IDX_W-1:0] wanted_q;
    logic [IDX_W-1:0] stale_seen;
    logic             pending_q;

    panel_view_t view_q[$];
    int          fail_count;
    int          seen_count;

    function automatic void adopt_remote(input logic [IDX_W-1:0] idx);
        shown_q    = idx;
        wanted_q   = idx;
        pending_q  = 1'b0;
        stale_seen = '0;
    endfunction

    function automatic panel_view_t reconcile_item(input req_t kind,
                                                   input logic signed [STEP_W-1:0] steps,
                                                   input logic [IDX_W-1:0] idx);
        panel_view_t view;
        longint      span;
        longint      total;
        longint      rem;
        view = '0;
        case (kind)
            REQ_MOVE:
            begin
                if (profiles == '0)
                    view.no_choice = 1'b1;
                else
                begin
                    span  = longint'(profiles);
                    total = longint'(shown_q) + longint'(steps);
                    rem   = total % span;
                    if (rem < 0)
                        rem += span;
                    view.next_index = rem[IDX_W-1:0];
                end
            end
            REQ_COMMIT:
            begin
                shown_q    = idx;
                wanted_q   = idx;
                pending_q  = 1'b1;
                stale_seen = '0;
            end
            REQ_TELEMETRY:
            begin
                if (!pending_q)
                    shown_q = idx;
                else if (idx == wanted_q)
                    adopt_remote(idx);
                else
                begin
                    if (stale_seen != COUNTER_MAX)
                        stale_seen = stale_seen + 1'b1;
                    if (stale_seen >= stale_max)
                        adopt_remote(idx);
                end
            end
            default: ;
        endcase
        view.shown_index     = shown_q;
        view.command_pending = pending_q;
        return view;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        panel_view_t want;
        if (!rst_n)
        begin
            profiles   = '0;
            stale_max  = STALE_LIMIT_RST;
            shown_q    = '0;
            wanted_q   = '0;
            stale_seen = '0;
            pending_q  = 1'b0;
            view_q.delete();
            fail_count = 0;
            seen_count = 0;
            mismatches      <= 0;
            in_flight       <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_count++;
                if (view_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] result with nothing outstanding: next=%0d none=%0b shown=%0d pend=%0b",
                                 $time, next_index, no_choice, shown_index, command_pending);
                end
                else
                begin
                    want = view_q.pop_front();
                    if (want.next_index !== next_index || want.no_choice !== no_choice ||
                        want.shown_index !== shown_index ||
                        want.command_pending !== command_pending)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result %0d: expected next=%0d none=%0b shown=%0d pend=%0b, got next=%0d none=%0b shown=%0d pend=%0b",
                                     $time, seen_count, want.next_index, want.no_choice,
                                     want.shown_index, want.command_pending, next_index,
                                     no_choice, shown_index, command_pending);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_addr_t'(cfg_index))
                    CFG_PROFILE_COUNT: profiles  = cfg_data;
                    CFG_STALE_LIMIT:   stale_max = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                view_q.push_back(reconcile_item(req_t'(req_type), step_count, index_value));

            mismatches      <= fail_count;
            in_flight       <= view_q.size();
            results_checked <= seen_count;
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import selr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600_000;
    localparam int          PHASE_ITEMS = 250;
    localparam int          HOLD_CYCLES = 600;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_A_W-1:0]       cfg_index;
    logic [CFG_D_W-1:0]       cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [REQ_W-1:0]         req_type;
    logic signed [STEP_W-1:0] step_count;
    logic [IDX_W-1:0]         index_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [IDX_W-1:0]         next_index;
    logic                     no_choice;
    logic [IDX_W-1:0]         shown_index;
    logic                     command_pending;

    int mismatches;
    int in_flight;
    int results_checked;

    logic        rx_hold = 1'b0;
    int          sent_total = 0;
    int          n_moves = 0;
    int          n_commits = 0;
    int          n_frames = 0;
    int          n_unused = 0;
    int          n_settings = 0;
    int unsigned cycle_count = 0;

    selection_reconciler_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .step_count      (step_count),
        .index_value     (index_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_index      (next_index),
        .no_choice       (no_choice),
        .shown_index     (shown_index),
        .command_pending (command_pending)
    );

    reconcile_monitor watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .step_count      (step_count),
        .index_value     (index_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_index      (next_index),
        .no_choice       (no_choice),
        .shown_index     (shown_index),
        .command_pending (command_pending),
        .mismatches      (mismatches),
        .in_flight       (in_flight),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("selection_reconciler_top: mismatch");
        $finish;
    end

    // result side: random stall after each transfer, quiet stretches, long hold-off
    initial
    begin : receiver
        int gap;
        int taken;
        gap   = 0;
        taken = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                taken++;
                gap = ((taken / 150) % 4 == 2) ? 0 : $urandom_range(0, 8);
            end
            else if (gap > 0)
                gap--;
            out_stall <= rx_hold || (gap != 0);
        end
    end

    // keep results blocked for a while so the block backs up onto its input
    initial
    begin
        wait (sent_total >= 700);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic post_item(input req_t kind, input logic [STEP_W-1:0] steps,
                             input logic [IDX_W-1:0] idx);
        int gap;
        gap = ((sent_total / 200) % 4 == 3) ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        step_count  <= steps;
        index_value <= idx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_total++;
        case (kind)
            REQ_MOVE:      n_moves++;
            REQ_COMMIT:    n_commits++;
            REQ_TELEMETRY: n_frames++;
            default:       n_unused++;
        endcase
    endtask

    task automatic write_reg(input cfg_addr_t which, input logic [CFG_D_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every result is out and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_profile(input logic [IDX_W-1:0] count, input logic [IDX_W-1:0] limit);
        settle();
        write_reg(CFG_PROFILE_COUNT, count);
        write_reg(CFG_STALE_LIMIT, limit);
        n_settings++;
    endtask

    function automatic logic [STEP_W-1:0] pick_steps();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40) - 20;
            1: return $urandom;
            2: return $urandom_range(0, 2000) - 1000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'hffff_ffff;
                    3: return 32'h0000_0001;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] count);
        if (count != '0 && $urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, count - 1));
        return IDX_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] other_than(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] pick;
        pick = IDX_W'($urandom);
        if (pick == idx)
            pick = pick ^ 8'h01;
        return pick;
    endfunction

    task automatic random_phase(input logic [IDX_W-1:0] count, input logic [IDX_W-1:0] limit);
        int               sent;
        int               run_len;
        logic [IDX_W-1:0] target;
        set_profile(count, limit);
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // commit, then moves and frames while the command is in flight
                    target = pick_index(count);
                    post_item(REQ_COMMIT, pick_steps(), target);
                    run_len = $urandom_range(1, int'(limit) + 2);
                    repeat (run_len)
                    begin
                        case ($urandom_range(0, 5))
                            0, 1: post_item(REQ_MOVE, pick_steps(), IDX_W'($urandom));
                            2:    post_item(REQ_TELEMETRY, pick_steps(), target);
                            default: post_item(REQ_TELEMETRY, pick_steps(), other_than(target));
                        endcase
                    end
                    sent += run_len + 1;
                end
                6:
                begin
                    // stale run straight to the point where the remote wins
                    target = pick_index(count);
                    post_item(REQ_COMMIT, pick_steps(), target);
                    repeat (int'(limit) + 1)
                        post_item(REQ_TELEMETRY, pick_steps(), other_than(target));
                    sent += int'(limit) + 2;
                end
                default:
                begin
                    post_item(req_t'($urandom_range(0, 3)), pick_steps(), IDX_W'($urandom));
                    sent++;
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_PROFILE_COUNT;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        req_type    <= REQ_MOVE;
        step_count  <= '0;
        index_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no profiles, stale limit 3
        post_item(REQ_MOVE, 32'h0000_0000, 8'd0);
        post_item(REQ_MOVE, 32'h8000_0000, 8'd0);
        post_item(REQ_COMMIT, 32'h0000_0000, 8'd255);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd7);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd7);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd255);
        post_item(REQ_NONE, 32'hffff_ffff, 8'd255);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd9);

        set_profile(8'd255, 8'd255);
        post_item(REQ_COMMIT, 32'h0000_0000, 8'd254);
        post_item(REQ_MOVE, 32'h7fff_ffff, 8'd0);
        post_item(REQ_MOVE, 32'h8000_0000, 8'd0);
        post_item(REQ_MOVE, 32'hffff_ffff, 8'd0);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd0);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd254);
        post_item(REQ_NONE, 32'h0000_0000, 8'd0);

        // zero stale limit: a wrong frame wins at once; shown above the count
        set_profile(8'd1, 8'd0);
        post_item(REQ_COMMIT, 32'h0000_0000, 8'd5);
        post_item(REQ_MOVE, 32'h0000_0003, 8'd0);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd9);

        set_profile(8'd7, 8'd5);
        post_item(REQ_COMMIT, 32'h0000_0000, 8'd200);
        post_item(REQ_MOVE, 32'hffff_fffb, 8'd0);
        repeat (3) post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd1);
        // limit lowered below the running count
        settle();
        write_reg(CFG_STALE_LIMIT, 8'd2);
        post_item(REQ_TELEMETRY, 32'h0000_0000, 8'd1);

        random_phase(8'd0, 8'd1);
        random_phase(8'd255, 8'd255);
        random_phase(8'd1, 8'd0);
        random_phase(8'd2, 8'd1);
        random_phase(8'd7, 8'd3);
        random_phase(IDX_W'($urandom_range(1, 255)), IDX_W'($urandom_range(1, 255)));
        random_phase(8'd128, 8'd5);
        random_phase(8'd255, 8'd1);

        settle();
        repeat (40) @(posedge clk);

        $display("Ran %0d items (%0d moves, %0d commits, %0d telemetry frames, %0d unused)",
                 sent_total, n_moves, n_commits, n_frames, n_unused);
        $display("over %0d register settings; %0d results checked, %0d failed",
                 n_settings, results_checked, mismatches);
        if (mismatches == 0 && in_flight == 0)
            $display("selection_reconciler_top: match");
        else
            $display("selection_reconciler_top: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/selr_pkg.sv
rtl/selr_mod.sv
rtl/selection_reconciler_top.sv
dv/reconcile_monitor.sv
dv/testbench.sv
